// ===== sv/regex_dot_star_matcher_defines.svh =====
// Assertion macros for the matcher's checker file.
// No dependencies; include by bare file name.
`ifndef REGEX_DOT_STAR_MATCHER_DEFINES_SVH
`define REGEX_DOT_STAR_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RDSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RDSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset too
`define RDSM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rdsm_pkg.sv =====
// Shared types and codes for the dot-star regular expression matcher.
// No dependencies; used by the matcher, its pattern store and its NFA core.
package rdsm_pkg;

   // Request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_ELEMENT = 2'd0,
      REQ_TEXT    = 2'd1,
      REQ_REPORT  = 2'd2
   } req_kind_type;

   // Per-word strobes from the top level, already qualified by the word firing
   typedef struct packed {
      logic load_elem;
      logic first_elem;
      logic text;
      logic report;
   } step_ctrl_type;

endpackage

// ===== sv/rdsm_pattern_store.sv =====
// Pattern element store: bytes, wildcard and star flags, length and overflow.
// Depends on rdsm_pkg for the step control struct.
module rdsm_pattern_store #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rdsm_pkg::step_ctrl_type                ctrl,
   input  logic [7:0]                             symbol,
   input  logic                                   any_char,
   input  logic                                   repeat_req,
   output logic [7:0]                             elem_bytes [MAX_ELEMENTS],
   output logic [MAX_ELEMENTS-1:0]                elem_wild,
   output logic [MAX_ELEMENTS-1:0]                elem_star,
   output logic [MAX_ELEMENTS-1:0]                elem_valid,
   output logic [$clog2(MAX_ELEMENTS+1)-1:0]      pattern_len,
   output logic                                   overflow
);

   localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
   localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   logic [7:0]              bytes_ff [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0] wild_ff;
   logic [MAX_ELEMENTS-1:0] star_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [LEN_W-1:0]        len_in;
   logic                    ovf_ff;
   logic                    ovf_in;
   logic [LEN_W-1:0]        base_len;
   logic                    has_room;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_idx;

   // A first element restarts the pattern before it is stored
   always_comb begin
      base_len = ctrl.first_elem ? '0 : len_ff;
      has_room = (base_len < LEN_W'(MAX_ELEMENTS));
      wr_en    = ctrl.load_elem & has_room;
      wr_idx   = base_len[IDX_W-1:0];
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      if (ctrl.load_elem) begin
         len_in = has_room ? base_len + LEN_W'(1) : base_len;
         ovf_in = (ctrl.first_elem ? 1'b0 : ovf_ff) | ~has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   // Element storage, one write port at the current length
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bytes_ff[wr_idx] <= symbol;
         wild_ff[wr_idx]  <= any_char;
         star_ff[wr_idx]  <= repeat_req;
      end
   end

   // Entries at or beyond the length are stale and masked off
   always_comb begin
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         elem_valid[k] = (LEN_W'(k) < len_ff);
         elem_bytes[k] = bytes_ff[k];
      end
   end

   assign elem_wild   = wild_ff;
   assign elem_star   = star_ff;
   assign pattern_len = len_ff;
   assign overflow    = ovf_ff;

endmodule

// ===== sv/rdsm_nfa_core.sv =====
// Active-position vector with star-skip closure and byte advance.
// Depends on rdsm_pkg; fed by rdsm_pattern_store.
module rdsm_nfa_core #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rdsm_pkg::step_ctrl_type            ctrl,
   input  logic [7:0]                         symbol,
   input  logic [7:0]                         elem_bytes [MAX_ELEMENTS],
   input  logic [MAX_ELEMENTS-1:0]            elem_wild,
   input  logic [MAX_ELEMENTS-1:0]            elem_star,
   input  logic [MAX_ELEMENTS-1:0]            elem_valid,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]  pattern_len,
   output logic                               end_hit
);

   localparam int NPOS = MAX_ELEMENTS + 1;
   localparam int LVLS = $clog2(NPOS);

   logic [NPOS-1:0]         active_ff;
   logic [NPOS-1:0]         active_in;
   logic [NPOS-1:0]         gen_lvl [LVLS+1];
   logic [NPOS-1:0]         prop_lvl [LVLS+1];
   logic [NPOS-1:0]         closed;
   logic [MAX_ELEMENTS-1:0] elem_hit;
   logic [NPOS-1:0]         advanced;

   // Skip closure as a prefix network: position i inherits from i-1 when
   // element i-1 is starred and part of the pattern
   always_comb begin
      gen_lvl[0]     = active_ff;
      prop_lvl[0][0] = 1'b0;
      for (int i = 1; i < NPOS; i++) begin
         prop_lvl[0][i] = elem_star[i-1] & elem_valid[i-1];
      end
      for (int l = 0; l < LVLS; l++) begin
         for (int i = 0; i < NPOS; i++) begin
            if (i >= (1 << l)) begin
               gen_lvl[l+1][i]  = gen_lvl[l][i] | (prop_lvl[l][i] & gen_lvl[l][i-(1<<l)]);
               prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i-(1<<l)];
            end else begin
               gen_lvl[l+1][i]  = gen_lvl[l][i];
               prop_lvl[l+1][i] = prop_lvl[l][i];
            end
         end
      end
      closed = gen_lvl[LVLS];
   end

   // Advance every matching position; starred elements also stay put
   always_comb begin
      advanced = '0;
      for (int k = 0; k < MAX_ELEMENTS; k++) begin
         elem_hit[k] = closed[k] & elem_valid[k]
                     & (elem_wild[k] | (elem_bytes[k] == symbol));
         advanced[k+1] = advanced[k+1] | elem_hit[k];
         advanced[k]   = advanced[k] | (elem_hit[k] & elem_star[k]);
      end
   end

   // Pattern loads and reports rearm to position zero
   always_comb begin
      active_in = active_ff;
      if (ctrl.load_elem || ctrl.report) begin
         active_in = NPOS'(1);
      end else if (ctrl.text) begin
         active_in = advanced;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= NPOS'(1);
      end else begin
         active_ff <= active_in;
      end
   end

   assign end_hit = closed[pattern_len];

endmodule

// ===== sv/regex_dot_star_matcher.sv =====
// Whole-text matcher for patterns of literal bytes and '.', each optionally
// starred. Load pattern elements (req_type 0, first=1 starts a new pattern),
// stream text bytes (req_type 1), then send a report word (req_type 2) that
// returns matched/too_long and rearms for the next text with the same pattern.
// One word is taken every clock while req_stall is low. A word waits in the
// input register, where it is decoded and resolved; a report's result then
// passes into the result register, which drives rsp_valid. A report holds
// req_stall high only while the result register holds a word that is itself
// stalled; other words never wait.
// The per-byte step is a prefix network over MAX_ELEMENTS+1 positions plus
// one byte compare per element.
// Patterns longer than MAX_ELEMENTS set too_long and force matched low.
// Depends on rdsm_pkg, rdsm_pattern_store and rdsm_nfa_core.
module regex_dot_star_matcher #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_symbol,
   input  logic       req_any_char,
   input  logic       req_repeat_req,
   input  logic       req_first,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_matched,
   output logic       rsp_too_long
);

   localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);

   logic                     in_vld_ff;
   logic                     in_vld_in;
   logic [1:0]               in_kind_ff;
   logic [7:0]               in_sym_ff;
   logic                     in_any_ff;
   logic                     in_rep_ff;
   logic                     in_first_ff;
   logic                     is_report;
   logic                     out_free;
   logic                     fire;
   rdsm_pkg::step_ctrl_type  ctrl;
   logic [7:0]               elem_bytes [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0]  elem_wild;
   logic [MAX_ELEMENTS-1:0]  elem_star;
   logic [MAX_ELEMENTS-1:0]  elem_valid;
   logic [LEN_W-1:0]         pattern_len;
   logic                     overflow;
   logic                     end_hit;
   logic                     rsp_vld_ff;
   logic                     rsp_vld_in;
   logic                     rsp_match_ff;
   logic                     rsp_match_in;
   logic                     rsp_long_ff;
   logic                     rsp_long_in;

   // A report waits only when the result register is full and stalled
   assign is_report = (in_kind_ff == rdsm_pkg::REQ_REPORT);
   assign out_free  = ~rsp_vld_ff | ~rsp_stall;
   assign fire      = in_vld_ff & (~is_report | out_free);
   assign req_stall = in_vld_ff & ~fire;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_kind_ff  <= req_type;
         in_sym_ff   <= req_symbol;
         in_any_ff   <= req_any_char;
         in_rep_ff   <= req_repeat_req;
         in_first_ff <= req_first;
      end
   end

   // Decode the word in the input register; unused codes do nothing
   always_comb begin
      ctrl = '0;
      if (fire) begin
         case (in_kind_ff)
            rdsm_pkg::REQ_ELEMENT: begin
               ctrl.load_elem  = 1'b1;
               ctrl.first_elem = in_first_ff;
            end
            rdsm_pkg::REQ_TEXT:   ctrl.text   = 1'b1;
            rdsm_pkg::REQ_REPORT: ctrl.report = 1'b1;
            default:              ctrl = '0;
         endcase
      end
   end

   rdsm_pattern_store #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .symbol      (in_sym_ff),
      .any_char    (in_any_ff),
      .repeat_req  (in_rep_ff),
      .elem_bytes  (elem_bytes),
      .elem_wild   (elem_wild),
      .elem_star   (elem_star),
      .elem_valid  (elem_valid),
      .pattern_len (pattern_len),
      .overflow    (overflow)
   );

   rdsm_nfa_core #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_nfa (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .symbol      (in_sym_ff),
      .elem_bytes  (elem_bytes),
      .elem_wild   (elem_wild),
      .elem_star   (elem_star),
      .elem_valid  (elem_valid),
      .pattern_len (pattern_len),
      .end_hit     (end_hit)
   );

   // Result register
   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_match_in = rsp_match_ff;
      rsp_long_in  = rsp_long_ff;
      if (ctrl.report) begin
         rsp_vld_in   = 1'b1;
         rsp_match_in = end_hit & ~overflow;
         rsp_long_in  = overflow;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
      rsp_long_ff  <= rsp_long_in;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_matched  = rsp_match_ff;
   assign rsp_too_long = rsp_long_ff;

endmodule

// ===== sv/rdsm_checker.sv =====
// Port-level checks for regex_dot_star_matcher, attached by bind.
// Depends on regex_dot_star_matcher_defines.svh.
`include "regex_dot_star_matcher_defines.svh"

module rdsm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_matched,
   input logic rsp_too_long
);

   // A stalled result word holds
   `RDSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_matched) && $stable(rsp_too_long),
      "rsp word changed while stalled")

   // A stalled request word stays offered
   `RDSM_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid,
      "req word withdrawn while stalled")

   // An overlong pattern never reports a match
   `RDSM_ASSERT_SAME(a_long_no_match, clock, reset, rsp_valid && rsp_too_long,
      !rsp_matched, "match reported with too_long set")

   // Nothing is pending right after reset
   `RDSM_ASSERT_ALWAYS_NEXT(a_rst_rsp_idle, clock, reset, !rsp_valid, "rsp_valid after reset")

   // The input register is empty right after reset
   `RDSM_ASSERT_ALWAYS_NEXT(a_rst_req_open, clock, reset, !req_stall, "req_stall after reset")

endmodule

bind regex_dot_star_matcher rdsm_checker u_rdsm_checker (.*);
